// ===== hdl/uil_pkg.sv =====
// ----------------------------------------------------------------------------
// uil_pkg
// Shared types and constants for the undoable indexed list.
// ----------------------------------------------------------------------------
package uil_pkg;

  localparam int LIST_DEPTH_D = 64;
  localparam int LOG_DEPTH_D  = 64;
  localparam int DATA_WIDTH_D = 32;

  localparam logic [2:0] K_INSERT    = 3'd0;
  localparam logic [2:0] K_APPEND    = 3'd1;
  localparam logic [2:0] K_OVERWRITE = 3'd2;
  localparam logic [2:0] K_REMOVE    = 3'd3;
  localparam logic [2:0] K_UNDO      = 3'd4;
  localparam logic [2:0] K_READ      = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_RANGE     = 2'd1;
  localparam logic [1:0] ST_LIST_FULL = 2'd2;
  localparam logic [1:0] ST_LOG_FULL  = 2'd3;

  localparam logic [1:0] J_INSERT    = 2'd0;
  localparam logic [1:0] J_OVERWRITE = 2'd1;
  localparam logic [1:0] J_REMOVE    = 2'd2;

  typedef struct packed {
    logic [2:0]         kind;
    logic [6:0]         position;
    logic signed [31:0] value;
    logic [6:0]         undo_steps;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic [6:0]         list_length;
    logic [6:0]         log_length;
    logic [6:0]         undone_count;
  } out_item_t;

endpackage

// ===== hdl/uil_ram.sv =====
// ----------------------------------------------------------------------------
// uil_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module uil_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/uil_front.sv =====
// ----------------------------------------------------------------------------
// uil_front
// Two-entry queue that decouples intake from execution.
// ----------------------------------------------------------------------------
module uil_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  uil_pkg::in_item_t in_data,
  output logic              q_valid,
  input  logic              q_pop,
  output uil_pkg::in_item_t q_data
);
  import uil_pkg::*;

  in_item_t  slot_r [2];
  logic      rd_ptr_r, wr_ptr_r;
  logic [1:0] cnt_r;
  logic      push;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_data;
    end
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (q_pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end
endmodule

// ===== hdl/uil_back.sv =====
// ----------------------------------------------------------------------------
// uil_back
// Execution sequencer: checks, shifts the list, journals edits, undoes them.
// ----------------------------------------------------------------------------
module uil_back #(
  parameter int LIST_DEPTH = 64,
  parameter int LOG_DEPTH  = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  output logic               q_pop,
  input  uil_pkg::in_item_t  q_data,
  output logic               out_valid,
  input  logic               out_stall,
  output uil_pkg::out_item_t out_data
);
  import uil_pkg::*;

  localparam int LA = $clog2(LIST_DEPTH);
  localparam int GA = $clog2(LOG_DEPTH);
  localparam int LC = $clog2(LIST_DEPTH + 1);
  localparam int GC = $clog2(LOG_DEPTH + 1);
  localparam int JW = 2 + LC + DATA_WIDTH;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_RD     = 9'b000000010,
    S_UPOP   = 9'b000000100,
    S_UWAIT  = 9'b000001000,
    S_UDEC   = 9'b000010000,
    S_SHUP_R = 9'b000100000,
    S_SHUP_W = 9'b001000000,
    S_SHDN_R = 9'b010000000,
    S_SHDN_W = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic [LC-1:0] ecnt_r, ecnt_nxt;
  logic [GC-1:0] gcnt_r, gcnt_nxt;
  logic [6:0]    undone_r, undone_nxt, steps_r, steps_nxt;
  logic [LC-1:0] idx_r, idx_nxt, pos_r, pos_nxt;
  logic [DATA_WIDTH-1:0] val_r, val_nxt;
  logic          undo_r, undo_nxt;
  logic          ovr_r, ovr_nxt;
  logic          busy_out_r;
  out_item_t     res_r, res_nxt;
  logic          res_ld;

  logic                  e_we;
  logic [LA-1:0]         e_wa, e_ra;
  logic [DATA_WIDTH-1:0] e_wd, e_rd;
  logic                  j_we;
  logic [GA-1:0]         j_wa, j_ra;
  logic [JW-1:0]         j_wd, j_rd;

  uil_ram #(.WIDTH(DATA_WIDTH), .DEPTH(LIST_DEPTH)) u_entries (
    .clk, .we(e_we), .waddr(e_wa), .wdata(e_wd), .raddr(e_ra), .rdata(e_rd));
  uil_ram #(.WIDTH(JW), .DEPTH(LOG_DEPTH)) u_journal (
    .clk, .we(j_we), .waddr(j_wa), .wdata(j_wd), .raddr(j_ra), .rdata(j_rd));

  logic [1:0]            j_op;
  logic [LC-1:0]         j_pos;
  logic [DATA_WIDTH-1:0] j_sv;
  assign {j_op, j_pos, j_sv} = j_rd;

  logic [LC-1:0] qpos;
  logic          qpos_ok;
  assign qpos_ok = (32'(q_data.position) <= 32'(LIST_DEPTH));
  assign qpos    = LC'(q_data.position);

  assign out_valid = busy_out_r;
  assign out_data  = res_r;

  function automatic out_item_t mk(input logic [1:0] st, input logic [DATA_WIDTH-1:0] rv,
                                   input logic [LC-1:0] el, input logic [GC-1:0] gl,
                                   input logic [6:0] un);
    out_item_t r;
    r.status       = st;
    r.read_value   = 32'(rv);
    r.list_length  = 7'(el);
    r.log_length   = 7'(gl);
    r.undone_count = un;
    return r;
  endfunction

  always_comb begin
    state_nxt = state_r; ecnt_nxt = ecnt_r; gcnt_nxt = gcnt_r;
    undone_nxt = undone_r; steps_nxt = steps_r; idx_nxt = idx_r; pos_nxt = pos_r;
    val_nxt = val_r; undo_nxt = undo_r; ovr_nxt = ovr_r;
    res_nxt = res_r; res_ld = 1'b0; q_pop = 1'b0;
    e_we = 1'b0; e_wa = '0; e_wd = '0; e_ra = '0;
    j_we = 1'b0; j_wa = GA'(gcnt_r); j_wd = '0; j_ra = '0;
    case (state_r)
      S_IDLE: begin
        if (q_valid && !busy_out_r) begin
          q_pop = 1'b1;
          pos_nxt = qpos;
          val_nxt = DATA_WIDTH'(q_data.value);
          undo_nxt = 1'b0;
          case (q_data.kind)
            K_INSERT, K_APPEND: begin
              if (q_data.kind == K_APPEND) pos_nxt = ecnt_r;
              if (q_data.kind == K_INSERT && (!qpos_ok || qpos > ecnt_r)) begin
                res_nxt = mk(ST_RANGE, '0, ecnt_r, gcnt_r, '0); res_ld = 1'b1;
              end else if (ecnt_r >= LC'(LIST_DEPTH)) begin
                res_nxt = mk(ST_LIST_FULL, '0, ecnt_r, gcnt_r, '0); res_ld = 1'b1;
              end else if (gcnt_r >= GC'(LOG_DEPTH)) begin
                res_nxt = mk(ST_LOG_FULL, '0, ecnt_r, gcnt_r, '0); res_ld = 1'b1;
              end else begin
                j_we = 1'b1;
                j_wd = {J_INSERT, pos_nxt, {DATA_WIDTH{1'b0}}};
                gcnt_nxt = gcnt_r + 1'b1;
                idx_nxt = ecnt_r;
                state_nxt = S_SHUP_R;
              end
            end
            K_OVERWRITE, K_REMOVE, K_READ: begin
              if (!qpos_ok || qpos >= ecnt_r) begin
                res_nxt = mk(ST_RANGE, '0, ecnt_r, gcnt_r, '0); res_ld = 1'b1;
              end else if (q_data.kind != K_READ && gcnt_r >= GC'(LOG_DEPTH)) begin
                res_nxt = mk(ST_LOG_FULL, '0, ecnt_r, gcnt_r, '0); res_ld = 1'b1;
              end else begin
                e_ra = LA'(qpos);
                ovr_nxt = (q_data.kind == K_OVERWRITE);
                state_nxt = S_RD;
                undo_nxt = (q_data.kind == K_READ);
              end
            end
            K_UNDO: begin
              undone_nxt = '0;
              steps_nxt = q_data.undo_steps;
              undo_nxt = 1'b1;
              state_nxt = S_UPOP;
            end
            default: begin
              res_nxt = mk(ST_OK, '0, ecnt_r, gcnt_r, '0); res_ld = 1'b1;
            end
          endcase
        end
      end
      S_RD: begin
        if (undo_r) begin
          res_nxt = mk(ST_OK, e_rd, ecnt_r, gcnt_r, '0); res_ld = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          // overwrite or removal: journal the displaced entry
          j_we = 1'b1;
          j_wd = {ovr_r ? J_OVERWRITE : J_REMOVE, pos_r, e_rd};
          gcnt_nxt = gcnt_r + 1'b1;
          if (ovr_r) begin
            e_we = 1'b1; e_wa = LA'(pos_r); e_wd = val_r;
            res_nxt = mk(ST_OK, '0, ecnt_r, gcnt_nxt, '0); res_ld = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            idx_nxt = pos_r;
            state_nxt = S_SHDN_R;
          end
        end
      end
      S_UPOP: begin
        if (undone_r >= steps_r || gcnt_r == '0) begin
          res_nxt = mk(ST_OK, '0, ecnt_r, gcnt_r, undone_r); res_ld = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          j_ra = GA'(gcnt_r - 1'b1);
          state_nxt = S_UWAIT;
        end
      end
      S_UWAIT: begin
        j_ra = GA'(gcnt_r - 1'b1);
        state_nxt = S_UDEC;
      end
      S_UDEC: begin
        gcnt_nxt = gcnt_r - 1'b1;
        undone_nxt = undone_r + 1'b1;
        pos_nxt = j_pos;
        val_nxt = j_sv;
        case (j_op)
          J_INSERT: begin
            if (j_pos < ecnt_r) begin
              idx_nxt = j_pos; ovr_nxt = 1'b0;
              state_nxt = S_SHDN_R;
            end else state_nxt = S_UPOP;
          end
          J_OVERWRITE: begin
            if (j_pos < ecnt_r) begin
              e_we = 1'b1; e_wa = LA'(j_pos); e_wd = j_sv;
            end
            state_nxt = S_UPOP;
          end
          default: begin
            if (ecnt_r < LC'(LIST_DEPTH) && j_pos <= ecnt_r) begin
              idx_nxt = ecnt_r;
              state_nxt = S_SHUP_R;
            end else state_nxt = S_UPOP;
          end
        endcase
      end
      S_SHUP_R: begin
        if (idx_r > pos_r) begin
          e_ra = LA'(idx_r - 1'b1);
          state_nxt = S_SHUP_W;
        end else begin
          e_we = 1'b1; e_wa = LA'(pos_r); e_wd = val_r;
          ecnt_nxt = ecnt_r + 1'b1;
          if (undo_r) state_nxt = S_UPOP;
          else begin
            res_nxt = mk(ST_OK, '0, ecnt_nxt, gcnt_r, '0); res_ld = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      S_SHUP_W: begin
        e_we = 1'b1; e_wa = LA'(idx_r); e_wd = e_rd;
        idx_nxt = idx_r - 1'b1;
        state_nxt = S_SHUP_R;
      end
      S_SHDN_R: begin
        if (idx_r + 1'b1 < ecnt_r) begin
          e_ra = LA'(idx_r + 1'b1);
          state_nxt = S_SHDN_W;
        end else begin
          ecnt_nxt = ecnt_r - 1'b1;
          if (undo_r) begin
            state_nxt = S_UPOP;
          end else begin
            res_nxt = mk(ST_OK, '0, ecnt_nxt, gcnt_r, '0); res_ld = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      S_SHDN_W: begin
        e_we = 1'b1; e_wa = LA'(idx_r); e_wd = e_rd;
        idx_nxt = idx_r + 1'b1;
        state_nxt = S_SHDN_R;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      ecnt_r     <= '0;
      gcnt_r     <= '0;
      busy_out_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ecnt_r  <= ecnt_nxt;
      gcnt_r  <= gcnt_nxt;
      if (res_ld) busy_out_r <= 1'b1;
      else if (!out_stall) busy_out_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ld) res_r <= res_nxt;
    undone_r <= undone_nxt; steps_r <= steps_nxt; idx_r <= idx_nxt; pos_r <= pos_nxt;
    val_r <= val_nxt; undo_r <= undo_nxt; ovr_r <= ovr_nxt;
  end
endmodule

// ===== hdl/undoable_indexed_list_top.sv =====
// ----------------------------------------------------------------------------
// undoable_indexed_list_top
// Indexed list with an undo journal.
//
// One input beat (kind, position, value, undo_steps) gives one output beat
// (status, read_value, list_length, log_length, undone_count). Both channels
// use valid/stall; a beat moves when valid is high and stall is low.
// A two-entry queue takes beats while the sequencer works. Rejected and
// unused kinds give their result straight from the checks; read and
// overwrite first read the entry (registered read). Insert and remove
// move the entries from the position on one by one, each a read then a
// write of the entry RAM (one read port, one write port). Undo reverts
// journal edits newest first, moving entries again where an edit needs it.
// The sequencer starts the next beat the cycle after its result is taken.
// Synchronous active-low reset empties the list and journal; no RAM clear.
// While out_stall holds back a result, the result holds and no new item
// starts; the queue keeps accepting until it is full.
// ----------------------------------------------------------------------------
module undoable_indexed_list_top #(
  parameter int LIST_DEPTH = uil_pkg::LIST_DEPTH_D,
  parameter int LOG_DEPTH  = uil_pkg::LOG_DEPTH_D,
  parameter int DATA_WIDTH = uil_pkg::DATA_WIDTH_D
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  uil_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output uil_pkg::out_item_t out_data
);
  import uil_pkg::*;

  logic     q_valid, q_pop;
  in_item_t q_data;

  uil_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .q_valid, .q_pop, .q_data);

  uil_back #(.LIST_DEPTH(LIST_DEPTH), .LOG_DEPTH(LOG_DEPTH), .DATA_WIDTH(DATA_WIDTH))
    u_back (.clk, .rst_n, .q_valid, .q_pop, .q_data, .out_valid, .out_stall, .out_data);

`ifndef SYNTHESIS
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.list_length <= 7'(LIST_DEPTH)) else $error("list length");
  a_log: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.log_length <= 7'(LOG_DEPTH)) else $error("log length");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data)) else $error("result hold");
`endif
endmodule
